// ===== rtl/sle_pkg.sv =====
// Shared types and constants for the sequential list engine.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package sle_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    // Request opcodes; the codes above OP_CLEAR do nothing
    localparam logic [OP_W-1:0] OP_READ    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Reply status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the request, read the store at its position
        logic decide;     // capture reply data and status
        logic start_ins;  // walk index starts at the list end
        logic start_del;  // walk index starts at the request position
        logic move_rd;    // read the neighbor of the walk index
        logic move_wr;    // write the neighbor word at the walk index, step
        logic write_val;  // store the request value at the request position
        logic inc_count;
        logic dec_count;
        logic clr_count;
        logic publish;    // load the output register
    } sle_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic is_replace;
        logic is_clear;
        logic op_ok;      // operation passes its position and full checks
        logic move_more;  // another word remains to shift
        logic out_free;   // output register can take a reply this cycle
    } sle_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sle_if.sv =====
// Valid/ready channel interfaces for requests and replies of the list engine.
// Depends on sle_pkg for the field widths.
`default_nettype none

interface sle_req_if;
    logic                        valid;
    logic                        ready;
    logic [sle_pkg::OP_W-1:0]    opcode;
    logic [sle_pkg::POS_W-1:0]   position;
    logic [sle_pkg::DATA_W-1:0]  value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface sle_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sle_pkg::DATA_W-1:0]    data_out;
    logic [sle_pkg::LEN_W-1:0]     list_length;
    logic [sle_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output data_out, output list_length, output status,
                    input ready);
    modport sink   (input valid, input data_out, input list_length, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sle_controller.sv =====
// Sequencing state machine of the list engine: accepts a request, steps the
// datapath through checks and word moves, and hands the reply off. Uses sle_pkg.
`default_nettype none

module sle_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire sle_pkg::sle_stat_t  stat,
    output sle_pkg::sle_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE_CHK,
        S_MOVE_WR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
                if (stat.op_ok)
                begin
                    if (stat.is_replace)
                    begin
                        cmd.write_val = 1'b1;
                    end
                    else if (stat.is_insert)
                    begin
                        cmd.start_ins = 1'b1;
                        state_next    = S_MOVE_CHK;
                    end
                    else if (stat.is_delete)
                    begin
                        cmd.start_del = 1'b1;
                        state_next    = S_MOVE_CHK;
                    end
                    else if (stat.is_clear)
                    begin
                        cmd.clr_count = 1'b1;
                    end
                end
            end
            S_MOVE_CHK:
            begin
                if (stat.move_more)
                begin
                    cmd.move_rd = 1'b1;
                    state_next  = S_MOVE_WR;
                end
                else
                begin
                    // gap is open (insert) or closed (delete): finish the update
                    if (stat.is_insert)
                    begin
                        cmd.write_val = 1'b1;
                        cmd.inc_count = 1'b1;
                    end
                    else
                    begin
                        cmd.dec_count = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_MOVE_CHK;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DECODE))
        else $error("accepted request did not move to decode");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_rd |=> cmd.move_wr)
        else $error("move read not followed by move write");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> req_ready)
        else $error("controller not idle after reply handoff");

endmodule

`default_nettype wire

// ===== rtl/sle_datapath.sv =====
// Datapath of the list engine: word store, length counter, walk index,
// request capture, position checks and the reply output register. Uses sle_pkg and sle_if.
`default_nettype none

module sle_datapath #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sle_pkg::sle_cmd_t             cmd,
    output sle_pkg::sle_stat_t                 stat,
    input  wire logic [sle_pkg::OP_W-1:0]      opcode,
    input  wire logic [sle_pkg::POS_W-1:0]     position,
    input  wire logic [sle_pkg::DATA_W-1:0]    value,
    sle_rsp_if.source                          rsp
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > sle_pkg::POS_W) ? CNT_W : sle_pkg::POS_W;

    logic [WIDTH-1:0]              mem [DEPTH];
    logic [WIDTH-1:0]              rd_data_reg;

    logic [sle_pkg::OP_W-1:0]      op_reg;
    logic [sle_pkg::POS_W-1:0]     pos_reg;
    logic [WIDTH-1:0]              val_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [AW-1:0]                 k_reg;
    logic [WIDTH-1:0]              res_data_reg;
    logic [sle_pkg::STATUS_W-1:0]  res_status_reg;

    logic                          out_valid_reg;
    logic [sle_pkg::DATA_W-1:0]    out_data_reg;
    logic [sle_pkg::LEN_W-1:0]     out_len_reg;
    logic [sle_pkg::STATUS_W-1:0]  out_status_reg;

    logic [CMP_W-1:0]              pos_cmp;
    logic [CMP_W-1:0]              cnt_cmp;
    logic [CMP_W-1:0]              k_cmp;
    logic                          in_range;
    logic                          ins_pos_ok;
    logic                          full;
    logic                          is_read;
    logic                          is_insert;
    logic                          is_delete;
    logic                          is_replace;
    logic                          is_clear;
    logic                          op_ok;
    logic [sle_pkg::STATUS_W-1:0]  status_code;

    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [WIDTH-1:0]              wr_data;

    assign pos_cmp    = CMP_W'(pos_reg);
    assign cnt_cmp    = CMP_W'(count_reg);
    assign k_cmp      = CMP_W'(k_reg);
    assign in_range   = (pos_cmp < cnt_cmp);
    assign ins_pos_ok = (pos_cmp <= cnt_cmp);
    assign full       = (count_reg >= CNT_W'(DEPTH));

    assign is_read    = (op_reg == sle_pkg::OP_READ);
    assign is_insert  = (op_reg == sle_pkg::OP_INSERT);
    assign is_delete  = (op_reg == sle_pkg::OP_DELETE);
    assign is_replace = (op_reg == sle_pkg::OP_REPLACE);
    assign is_clear   = (op_reg == sle_pkg::OP_CLEAR);

    always_comb
    begin
        op_ok       = 1'b0;
        status_code = sle_pkg::ST_OK;
        case (op_reg)
            sle_pkg::OP_READ, sle_pkg::OP_DELETE, sle_pkg::OP_REPLACE:
            begin
                op_ok       = in_range;
                status_code = in_range ? sle_pkg::ST_OK : sle_pkg::ST_BADPOS;
            end
            sle_pkg::OP_INSERT:
            begin
                // bad position takes priority over a full list
                op_ok = ins_pos_ok && !full;
                if (!ins_pos_ok)
                begin
                    status_code = sle_pkg::ST_BADPOS;
                end
                else if (full)
                begin
                    status_code = sle_pkg::ST_FULL;
                end
            end
            sle_pkg::OP_CLEAR:
            begin
                op_ok = 1'b1;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stat.is_insert  = is_insert;
        stat.is_delete  = is_delete;
        stat.is_replace = is_replace;
        stat.is_clear   = is_clear;
        stat.op_ok      = op_ok;
        // insert walks down from the list end, delete walks up from the position
        stat.move_more  = is_insert ? (k_cmp > pos_cmp) : ((k_cmp + CMP_W'(1)) < cnt_cmp);
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    // Store ports
    assign rd_en   = cmd.load || cmd.move_rd;
    assign rd_addr = cmd.load  ? AW'(position)
                   : is_insert ? (k_reg - AW'(1))
                   :             (k_reg + AW'(1));
    assign wr_en   = cmd.move_wr || cmd.write_val;
    assign wr_addr = cmd.move_wr ? k_reg : AW'(pos_reg);
    assign wr_data = cmd.move_wr ? rd_data_reg : val_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request capture and reply data
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= WIDTH'(value);
        end
        if (cmd.decide)
        begin
            res_data_reg   <= (op_ok && (is_read || is_delete || is_replace)) ? rd_data_reg
                                                                              : '0;
            res_status_reg <= status_code;
        end
        if (cmd.start_ins)
        begin
            k_reg <= AW'(count_reg);
        end
        else if (cmd.start_del)
        begin
            k_reg <= AW'(pos_reg);
        end
        else if (cmd.move_wr)
        begin
            k_reg <= is_insert ? (k_reg - AW'(1)) : (k_reg + AW'(1));
        end
        if (cmd.publish)
        begin
            out_data_reg   <= sle_pkg::DATA_W'(res_data_reg);
            out_len_reg    <= sle_pkg::LEN_W'(count_reg);
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.inc_count)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.data_out    = out_data_reg;
    assign rsp.list_length = out_len_reg;
    assign rsp.status      = out_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list length above store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.inc_count |-> !full)
        else $error("length increment on a full list");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_count |-> (count_reg != '0))
        else $error("length decrement on an empty list");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || rsp.ready))
        else $error("reply overwrites a transaction not yet taken");

endmodule

`default_nettype wire

// ===== rtl/sequential_list_engine_core.sv =====
// Sequential list engine: an ordered list of up to DEPTH words of WIDTH bits.
// Channels: req (opcode, position, value) and rsp (data_out, list_length,
// status), both valid/ready; a transaction moves at an edge with valid and
// ready high. Exactly one rsp transaction follows each req transaction, in order.
// States from req transaction to rsp valid, with the receiver ready:
//   read, replace, clear, unused opcodes, rejected requests: decode, finish
//   insert at p: decode, length - p word moves, write of the value, finish
//   delete at p: decode, length - 1 - p word moves, finish
// One request is worked at a time; the next is taken once the previous reply
// sits in the output register. Each word move of an insert or delete is a read
// and a write: the store has one read and one write port with registered read
// data, so a word is read in one cycle and written one place over in the next.
// Reset clears the length and the output valid; the store holds no reset
// value and needs no clearing pass, since only words below the length are read.
// A stalled receiver holds the reply in the output register; one more request
// may be taken and worked meanwhile, and it waits for the register to drain.
// Depends on sle_pkg, sle_if, sle_controller and sle_datapath.
`default_nettype none

module sequential_list_engine_core #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);

    sle_pkg::sle_cmd_t  cmd;
    sle_pkg::sle_stat_t stat;

    sle_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sle_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .opcode   (req.opcode),
        .position (req.position),
        .value    (req.value),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
